>>> src/its_pkg.sv
// ----------------------------------------------------------------------------
// Intercept time solver package
// Shared constants, register indexes and the solution mode type.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int Q_FRAC         = 16;

    localparam logic [15:0] NEAR_ZERO_RST = 16'd7;
    localparam logic [15:0] MIN_TIME_RST  = 16'd7;

    localparam logic REG_NEAR_ZERO = 1'b0;
    localparam logic REG_MIN_TIME  = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_LIN,
        MODE_QUAD
    } t_mode;

endpackage

>>> src/its_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One root bit per cell of a restoring integer square root, with sideband.
// ----------------------------------------------------------------------------
module its_sqrt_cell #(
    parameter int SW = 50,
    parameter int TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*SW-1:0]   i_rad,
    input  logic [SW+1:0]     i_rem,
    input  logic [SW-1:0]     i_root,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [2*SW-1:0]   o_rad,
    output logic [SW+1:0]     o_rem,
    output logic [SW-1:0]     o_root,
    output logic [TW-1:0]     o_tag
);

    logic [SW+3:0] w_cur;
    logic [SW+3:0] w_trial;
    logic [SW+3:0] w_diff;
    logic          w_ge;

    assign w_cur   = {i_rem, i_rad[2*SW-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_ge    = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[2*SW-3:0], 2'b00};
            o_rem  <= w_ge ? w_diff[SW+1:0] : w_cur[SW+1:0];
            o_root <= {i_root[SW-2:0], w_ge};
            o_tag  <= i_tag;
        end
    end

endmodule

>>> src/its_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit per cell of a restoring unsigned divide.
// ----------------------------------------------------------------------------
module its_div_cell #(
    parameter int NW  = 67,
    parameter int DVW = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NW-1:0]    i_num,
    input  logic [DVW-1:0]   i_den,
    input  logic [DVW-1:0]   i_rem,
    input  logic [31:0]      i_q,
    input  logic             i_big,
    input  logic             i_ok,
    output logic             o_valid,
    output logic [NW-1:0]    o_num,
    output logic [DVW-1:0]   o_den,
    output logic [DVW-1:0]   o_rem,
    output logic [31:0]      o_q,
    output logic             o_big,
    output logic             o_ok
);

    logic [DVW:0] w_cur;
    logic [DVW:0] w_diff;
    logic         w_ge;

    assign w_cur  = {i_rem, i_num[NW-1]};
    assign w_ge   = (w_cur >= {1'b0, i_den});
    assign w_diff = w_cur - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[NW-2:0], 1'b0};
            o_den <= i_den;
            o_rem <= w_ge ? w_diff[DVW-1:0] : w_cur[DVW-1:0];
            o_q   <= {i_q[30:0], w_ge};
            o_big <= i_big | i_q[31];
            o_ok  <= i_ok;
        end
    end

endmodule

>>> src/intercept_time_solver.sv
// ----------------------------------------------------------------------------
// Intercept time solver
// Earliest positive projectile intercept time from offset, velocity, speed.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the result side takes words. The
// pipeline is 2*COORD_BITS+2 cells of the square root chain plus
// 2*COORD_BITS+19 cells of the two parallel divider chains plus seven
// arithmetic stages. The whole pipeline holds while a finished word waits
// at the output.
module intercept_time_solver #(
    parameter int COORD_BITS = its_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [15:0]                  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_rel_x,
    input  logic signed [COORD_BITS-1:0] i_rel_y,
    input  logic signed [COORD_BITS-1:0] i_rel_z,
    input  logic signed [COORD_BITS-1:0] i_vel_x,
    input  logic signed [COORD_BITS-1:0] i_vel_y,
    input  logic signed [COORD_BITS-1:0] i_vel_z,
    input  logic [COORD_BITS-2:0]        i_shot_speed,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [31:0]                  o_hit_time,
    output logic                         o_found
);

    localparam int W   = COORD_BITS;
    localparam int CW  = 2*W+2;
    localparam int H   = W+1;
    localparam int DW  = 4*W+4;
    localparam int SW  = 2*W+2;
    localparam int NS  = 2*W+4;
    localparam int NW  = 2*W+3+its_pkg::Q_FRAC;
    localparam int DVW = 2*W+2;
    localparam int TW  = 3*CW+2;

    logic [15:0] r_near_zero;
    logic [15:0] r_min_time;
    logic        w_en;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_zero <= its_pkg::NEAR_ZERO_RST;
            r_min_time  <= its_pkg::MIN_TIME_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == its_pkg::REG_NEAR_ZERO) begin
                r_near_zero <= i_cfg_data;
            end else begin
                r_min_time <= i_cfg_data;
            end
        end
    end

    // Stage 1: products.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [2*W-1:0] r_vxx, r_vyy, r_vzz, r_dxx, r_dyy, r_dzz;
    logic signed [2*W-1:0] r_dxv, r_dyv, r_dzv;
    logic [2*W-3:0]        r_ss;

    logic                w_sq_valid [SW+1];
    logic [2*SW-1:0]     w_sq_rad   [SW+1];
    logic [SW+1:0]       w_sq_rem   [SW+1];
    logic [SW-1:0]       w_sq_root  [SW+1];
    logic [TW-1:0]       w_sq_tag   [SW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= w_sq_valid[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vxx <= i_vel_x * i_vel_x;
            r_vyy <= i_vel_y * i_vel_y;
            r_vzz <= i_vel_z * i_vel_z;
            r_dxx <= i_rel_x * i_rel_x;
            r_dyy <= i_rel_y * i_rel_y;
            r_dzz <= i_rel_z * i_rel_z;
            r_dxv <= i_rel_x * i_vel_x;
            r_dyv <= i_rel_y * i_vel_y;
            r_dzv <= i_rel_z * i_vel_z;
            r_ss  <= i_shot_speed * i_shot_speed;
        end
    end

    // Stage 2: coefficients.
    logic signed [CW-1:0] r_a2, r_b2, r_c2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a2 <= CW'(r_vxx) + CW'(r_vyy) + CW'(r_vzz) - $signed(CW'(r_ss));
            r_b2 <= (CW'(r_dxv) + CW'(r_dyv) + CW'(r_dzv)) <<< 1;
            r_c2 <= CW'(r_dxx) + CW'(r_dyy) + CW'(r_dzz);
        end
    end

    // Stage 3: zero tests and partial products.
    logic [CW-1:0]        w_amag, w_bmag, w_cu;
    logic                 w_za, w_zb;
    its_pkg::t_mode       w_mode3;
    logic signed [CW-1:0] r_a3, r_b3, r_c3;
    its_pkg::t_mode       r_mode3;
    logic [2*H-1:0]       r_bhh, r_bhl, r_bll, r_ahch, r_ahcl, r_alch, r_alcl;

    assign w_amag = r_a2[CW-1] ? CW'(-r_a2) : CW'(r_a2);
    assign w_bmag = r_b2[CW-1] ? CW'(-r_b2) : CW'(r_b2);
    assign w_cu   = CW'(r_c2);
    assign w_za   = (r_a2 == '0) || (w_amag < CW'(r_near_zero));
    assign w_zb   = (r_b2 == '0) || (w_bmag < CW'(r_near_zero));

    always_comb begin
        if (!w_za) begin
            w_mode3 = its_pkg::MODE_QUAD;
        end else if (!w_zb) begin
            w_mode3 = its_pkg::MODE_LIN;
        end else begin
            w_mode3 = its_pkg::MODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a3    <= r_a2;
            r_b3    <= r_b2;
            r_c3    <= r_c2;
            r_mode3 <= w_mode3;
            r_bhh   <= w_bmag[2*H-1:H] * w_bmag[2*H-1:H];
            r_bhl   <= w_bmag[2*H-1:H] * w_bmag[H-1:0];
            r_bll   <= w_bmag[H-1:0] * w_bmag[H-1:0];
            r_ahch  <= w_amag[2*H-1:H] * w_cu[2*H-1:H];
            r_ahcl  <= w_amag[2*H-1:H] * w_cu[H-1:0];
            r_alch  <= w_amag[H-1:0] * w_cu[2*H-1:H];
            r_alcl  <= w_amag[H-1:0] * w_cu[H-1:0];
        end
    end

    // Stage 4: sums of partial products.
    logic signed [CW-1:0] r_a4, r_b4, r_c4;
    its_pkg::t_mode       r_mode4;
    logic [DW-1:0]        r_bb, r_ac;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a4    <= r_a3;
            r_b4    <= r_b3;
            r_c4    <= r_c3;
            r_mode4 <= r_mode3;
            r_bb    <= (DW'(r_bhh) << (2*H)) + (DW'(r_bhl) << (H+1)) + DW'(r_bll);
            r_ac    <= (DW'(r_ahch) << (2*H)) + ((DW'(r_ahcl) + DW'(r_alch)) << H)
                       + DW'(r_alcl);
        end
    end

    // Stage 5: discriminant.
    logic [DW-1:0]        w_disc;
    its_pkg::t_mode       w_mode5;
    logic [DW-1:0]        r_rad;
    logic [TW-1:0]        r_tag5;

    assign w_disc = r_a4[CW-1] ? (r_bb + (r_ac << 2)) : (r_bb - (r_ac << 2));

    always_comb begin
        w_mode5 = r_mode4;
        if (r_mode4 == its_pkg::MODE_QUAD && w_disc[DW-1]) begin
            w_mode5 = its_pkg::MODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad  <= (w_mode5 == its_pkg::MODE_QUAD) ? w_disc : '0;
            r_tag5 <= {w_mode5, r_a4, r_b4, r_c4};
        end
    end

    // Square root chain.
    assign w_sq_valid[0] = r_v5;
    assign w_sq_rad[0]   = r_rad;
    assign w_sq_rem[0]   = '0;
    assign w_sq_root[0]  = '0;
    assign w_sq_tag[0]   = r_tag5;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        its_sqrt_cell #(.SW(SW), .TW(TW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[k]),
            .i_rad   (w_sq_rad[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_tag   (w_sq_tag[k]),
            .o_valid (w_sq_valid[k+1]),
            .o_rad   (w_sq_rad[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_tag   (w_sq_tag[k+1])
        );
    end

    // Stage 6: root numerators and divider operands.
    its_pkg::t_mode       w_mode6;
    logic signed [CW-1:0] w_a6, w_b6, w_c6;
    logic signed [NS-1:0] w_nb, w_sqs, w_den_q;
    logic signed [NS-1:0] w_n1, w_d1, w_n2, w_d2;
    logic [NS-1:0]        w_n1m, w_d1m, w_n2m, w_d2m;
    logic                 w_ok1, w_ok2;
    logic [NW-1:0]        r_num1, r_num2;
    logic [DVW-1:0]       r_den1, r_den2;
    logic                 r_ok1, r_ok2;

    assign w_mode6 = its_pkg::t_mode'(w_sq_tag[SW][TW-1 -: 2]);
    assign w_a6    = w_sq_tag[SW][3*CW-1:2*CW];
    assign w_b6    = w_sq_tag[SW][2*CW-1:CW];
    assign w_c6    = w_sq_tag[SW][CW-1:0];
    assign w_nb    = -NS'(w_b6);
    assign w_sqs   = $signed({2'b00, w_sq_root[SW]});
    assign w_den_q = NS'(w_a6) <<< 1;

    always_comb begin
        w_ok1 = 1'b0;
        w_ok2 = 1'b0;
        unique case (w_mode6)
            its_pkg::MODE_LIN: begin
                w_n1  = -NS'(w_c6);
                w_d1  = NS'(w_b6);
                w_ok1 = 1'b1;
            end
            its_pkg::MODE_QUAD: begin
                w_n1  = w_nb - w_sqs;
                w_d1  = w_den_q;
                w_ok1 = 1'b1;
                w_ok2 = 1'b1;
            end
            default: begin
                w_n1 = w_nb - w_sqs;
                w_d1 = w_den_q;
            end
        endcase
        w_n2 = w_nb + w_sqs;
        w_d2 = w_den_q;
        w_ok1 = w_ok1 && (w_n1 != '0) && (w_n1[NS-1] == w_d1[NS-1]);
        w_ok2 = w_ok2 && (w_n2 != '0) && (w_n2[NS-1] == w_d2[NS-1]);
    end

    assign w_n1m = w_n1[NS-1] ? NS'(-w_n1) : NS'(w_n1);
    assign w_d1m = w_d1[NS-1] ? NS'(-w_d1) : NS'(w_d1);
    assign w_n2m = w_n2[NS-1] ? NS'(-w_n2) : NS'(w_n2);
    assign w_d2m = w_d2[NS-1] ? NS'(-w_d2) : NS'(w_d2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num1 <= {w_n1m[NS-2:0], {its_pkg::Q_FRAC{1'b0}}};
            r_num2 <= {w_n2m[NS-2:0], {its_pkg::Q_FRAC{1'b0}}};
            r_den1 <= w_d1m[DVW-1:0];
            r_den2 <= w_d2m[DVW-1:0];
            r_ok1  <= w_ok1;
            r_ok2  <= w_ok2;
        end
    end

    // Divider chains, one per root.
    logic            w_dv_valid [2][NW+1];
    logic [NW-1:0]   w_dv_num   [2][NW+1];
    logic [DVW-1:0]  w_dv_den   [2][NW+1];
    logic [DVW-1:0]  w_dv_rem   [2][NW+1];
    logic [31:0]     w_dv_q     [2][NW+1];
    logic            w_dv_big   [2][NW+1];
    logic            w_dv_ok    [2][NW+1];

    assign w_dv_valid[0][0] = r_v6;
    assign w_dv_valid[1][0] = r_v6;
    assign w_dv_num[0][0]   = r_num1;
    assign w_dv_num[1][0]   = r_num2;
    assign w_dv_den[0][0]   = r_den1;
    assign w_dv_den[1][0]   = r_den2;
    assign w_dv_ok[0][0]    = r_ok1;
    assign w_dv_ok[1][0]    = r_ok2;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign w_dv_rem[l][0] = '0;
        assign w_dv_q[l][0]   = '0;
        assign w_dv_big[l][0] = 1'b0;
        for (genvar k = 0; k < NW; k++) begin : g_div
            its_div_cell #(.NW(NW), .DVW(DVW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_dv_valid[l][k]),
                .i_num   (w_dv_num[l][k]),
                .i_den   (w_dv_den[l][k]),
                .i_rem   (w_dv_rem[l][k]),
                .i_q     (w_dv_q[l][k]),
                .i_big   (w_dv_big[l][k]),
                .i_ok    (w_dv_ok[l][k]),
                .o_valid (w_dv_valid[l][k+1]),
                .o_num   (w_dv_num[l][k+1]),
                .o_den   (w_dv_den[l][k+1]),
                .o_rem   (w_dv_rem[l][k+1]),
                .o_q     (w_dv_q[l][k+1]),
                .o_big   (w_dv_big[l][k+1]),
                .o_ok    (w_dv_ok[l][k+1])
            );
        end
    end

    // Output stage: saturation, threshold and earliest root.
    logic [31:0] w_t1, w_t2;
    logic        w_acc1, w_acc2;
    logic [31:0] n_hit_time;
    logic        n_found;

    assign w_t1   = w_dv_big[0][NW] ? '1 : w_dv_q[0][NW];
    assign w_t2   = w_dv_big[1][NW] ? '1 : w_dv_q[1][NW];
    assign w_acc1 = w_dv_ok[0][NW] && (w_t1 > {16'd0, r_min_time});
    assign w_acc2 = w_dv_ok[1][NW] && (w_t2 > {16'd0, r_min_time});

    always_comb begin
        n_found = w_acc1 || w_acc2;
        priority if (w_acc1 && w_acc2) begin
            n_hit_time = (w_t1 < w_t2) ? w_t1 : w_t2;
        end else if (w_acc1) begin
            n_hit_time = w_t1;
        end else if (w_acc2) begin
            n_hit_time = w_t2;
        end else begin
            n_hit_time = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_dv_valid[0][NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit_time <= n_hit_time;
            o_found    <= n_found;
        end
    end

endmodule

>>> src/its_checker.sv
// ----------------------------------------------------------------------------
// Intercept time solver checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module its_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_hit_time,
    input logic        o_found
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_time)
        && $stable(o_found))
        else $error("stalled output word changed");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_hit_time == 32'd0)
        else $error("time not zero on a miss");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_hit_time != 32'd0)
        else $error("zero time on a hit");

endmodule

bind intercept_time_solver its_checker u_its_checker (.*);

>>> tb/intercept_time_solver_test.sv
// ----------------------------------------------------------------------------
// Intercept time solver testbench
// Drives offset, velocity and speed words through the valid/ready input,
// predicts each intercept time with exact wide integer arithmetic and
// compares every result word in order while both sides idle at random.
// ----------------------------------------------------------------------------
module intercept_time_solver_test;

    localparam int CB       = 24;
    localparam int WDOG_MAX = 5000;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN    = 300;

    typedef struct packed {
        logic signed [CB-1:0] rx;
        logic signed [CB-1:0] ry;
        logic signed [CB-1:0] rz;
        logic signed [CB-1:0] vx;
        logic signed [CB-1:0] vy;
        logic signed [CB-1:0] vz;
        logic [CB-2:0]        speed;
    } t_query;

    typedef struct packed {
        logic [31:0] hit_time;
        logic        found;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = its_pkg::REG_NEAR_ZERO;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [CB-1:0] i_rel_x = '0, i_rel_y = '0, i_rel_z = '0;
    logic signed [CB-1:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic [CB-2:0] i_shot_speed = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [31:0] o_hit_time;
    logic o_found;

    t_query  pending_queries[$];
    t_answer expected_answers[$];
    logic [15:0] near_zero_q = its_pkg::NEAR_ZERO_RST;
    logic [15:0] min_time_q  = its_pkg::MIN_TIME_RST;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    intercept_time_solver #(.COORD_BITS(CB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_rel_x(i_rel_x), .i_rel_y(i_rel_y), .i_rel_z(i_rel_z),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_vel_z(i_vel_z),
        .i_shot_speed(i_shot_speed),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit_time(o_hit_time), .o_found(o_found)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [191:0] mag(logic signed [191:0] x);
        return x[191] ? -x : x;
    endfunction

    function automatic logic is_negligible(logic signed [191:0] x);
        return (x == 0) || (mag(x) < {176'd0, near_zero_q});
    endfunction

    function automatic logic [191:0] isqrt(logic [191:0] n);
        logic [191:0] r, c;
        r = '0;
        for (int k = 95; k >= 0; k--) begin
            c = r | (192'd1 << k);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // Returns {accepted, time} for the quotient num/den in Q16.16.
    function automatic logic [32:0] q16_time(logic signed [191:0] num,
                                             logic signed [191:0] den);
        logic [191:0] q;
        logic [31:0] v;
        q = (mag(num) << 16) / mag(den);
        v = (q[191:32] != 0) ? 32'hFFFF_FFFF : q[31:0];
        if (num == 0 || num[191] != den[191]) return {1'b0, v};
        return {(v > {16'd0, min_time_q}), v};
    endfunction

    function automatic t_answer solve_intercept(t_query q);
        logic signed [191:0] dx, dy, dz, vx, vy, vz, s, a, b, c, disc, sq;
        logic [32:0] r1, r2;
        t_answer ans;
        dx = q.rx; dy = q.ry; dz = q.rz;
        vx = q.vx; vy = q.vy; vz = q.vz;
        s = $signed({169'd0, q.speed});
        a = vx * vx + vy * vy + vz * vz - s * s;
        b = 2 * (dx * vx + dy * vy + dz * vz);
        c = dx * dx + dy * dy + dz * dz;
        ans = '0;
        if (is_negligible(a)) begin
            if (!is_negligible(b)) begin
                r1 = q16_time(-c, b);
                if (r1[32]) ans = {r1[31:0], 1'b1};
            end
        end else begin
            disc = b * b - 4 * a * c;
            if (!disc[191]) begin
                sq = isqrt(disc);
                r1 = q16_time(-b - sq, a + a);
                r2 = q16_time(-b + sq, a + a);
                if (r1[32] && r2[32])
                    ans = {(r1[31:0] < r2[31:0]) ? r1[31:0] : r2[31:0], 1'b1};
                else if (r1[32]) ans = {r1[31:0], 1'b1};
                else if (r2[32]) ans = {r2[31:0], 1'b1};
            end
        end
        return ans;
    endfunction

    // Input driver.
    always @(posedge i_clk) begin
        t_query nq;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                expected_answers.push_back(solve_intercept({i_rel_x, i_rel_y, i_rel_z,
                    i_vel_x, i_vel_y, i_vel_z, i_shot_speed}));
            if (!i_in_valid || o_in_ready) begin
                if (pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nq = pending_queries.pop_front();
                    i_rel_x <= nq.rx; i_rel_y <= nq.ry; i_rel_z <= nq.rz;
                    i_vel_x <= nq.vx; i_vel_y <= nq.vy; i_vel_z <= nq.vz;
                    i_shot_speed <= nq.speed;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: hit_time %h found %b",
                                 o_hit_time, o_found);
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (o_hit_time !== exp_a.hit_time || o_found !== exp_a.found) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit_time %h found %b, got %h %b",
                                     exp_a.hit_time, exp_a.found, o_hit_time, o_found);
                    end
                end
            end
        end
    end

    // Receiver ready, with the long hold-off counted here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_requests != hold_seen) begin
                hold_seen <= hold_requests;
                hold_left <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [CB-1:0] rand_span(int m);
        return CB'($signed($urandom_range(0, 2 * m)) - m);
    endfunction

    function automatic t_query make_query(int rx, int ry, int rz, int vx, int vy,
                                          int vz, int sp);
        return {CB'(rx), CB'(ry), CB'(rz), CB'(vx), CB'(vy), CB'(vz), (CB-1)'(sp)};
    endfunction

    function automatic t_query random_query();
        t_query q;
        int kind, s;
        kind = $urandom_range(99);
        q.rx = rand_span(4096); q.ry = rand_span(4096); q.rz = rand_span(4096);
        q.vx = rand_span(1024); q.vy = rand_span(1024); q.vz = rand_span(1024);
        q.speed = (CB-1)'($urandom_range(1800, 6000));
        if (kind < 20) begin
            q.rx = CB'($urandom()); q.ry = CB'($urandom()); q.rz = CB'($urandom());
            q.vx = CB'($urandom()); q.vy = CB'($urandom()); q.vz = CB'($urandom());
            q.speed = (CB-1)'($urandom());
        end else if (kind < 35) begin
            s = $urandom_range(0, 3000);
            q.vx = $urandom_range(1) ? CB'(s) : CB'(-s);
            q.vy = CB'($urandom_range(0, 2));
            q.vz = '0;
            q.speed = (CB-1)'(s);
        end else if (kind < 50) begin
            q.speed = (CB-1)'($urandom_range(0, 900));
        end
        return q;
    endfunction

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == its_pkg::REG_NEAR_ZERO) near_zero_q = val;
        else min_time_q = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_queries.size() > 0 || i_in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) pending_queries.push_back(random_query());
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: extremes, zero coefficients, linear and negative cases.
        pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(8388607, 8388607, 8388607,
                                             8388607, 8388607, 8388607, 8388607));
        pending_queries.push_back(make_query(-8388608, -8388608, -8388608,
                                             -8388608, -8388608, -8388608, 0));
        pending_queries.push_back(make_query(8388607, -8388608, 8388607,
                                             -8388608, 8388607, -8388608, 8388607));
        pending_queries.push_back(make_query(2560, 0, 0, 0, 0, 0, 256));
        pending_queries.push_back(make_query(2560, 0, 0, -256, 0, 0, 256));
        pending_queries.push_back(make_query(2560, 0, 0, 256, 0, 0, 256));
        pending_queries.push_back(make_query(2560, 0, 0, 512, 0, 0, 256));
        pending_queries.push_back(make_query(-2560, 0, 0, 512, 0, 0, 256));
        pending_queries.push_back(make_query(1, 0, 0, 0, 0, 0, 8388607));
        pending_queries.push_back(make_query(0, 0, 0, 100, 0, 0, 50));
        pending_queries.push_back(make_query(8388607, 0, 0, 0, 0, 0, 1));
        pending_queries.push_back(make_query(0, 0, 0, 256, 2, 0, 256));
        pending_queries.push_back(make_query(1000, 1000, 0, -300, 0, 0, 301));
        pending_queries.push_back(make_query(3, 0, 0, 0, 0, 0, 2));
        wait_drained();

        run_random(200, 0, 0);
        write_reg(its_pkg::REG_NEAR_ZERO, 16'd0);
        write_reg(its_pkg::REG_MIN_TIME, 16'd0);
        run_random(200, 66, 0);
        write_reg(its_pkg::REG_NEAR_ZERO, 16'hFFFF);
        write_reg(its_pkg::REG_MIN_TIME, 16'hFFFF);
        run_random(200, 0, 66);
        write_reg(its_pkg::REG_NEAR_ZERO, 16'($urandom_range(0, 300)));
        write_reg(its_pkg::REG_MIN_TIME, 16'($urandom));
        run_random(200, 29, 29);

        // Long receiver hold-off with the sender pushing continuously.
        write_reg(its_pkg::REG_NEAR_ZERO, its_pkg::NEAR_ZERO_RST);
        write_reg(its_pkg::REG_MIN_TIME, its_pkg::MIN_TIME_RST);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 250; i++) pending_queries.push_back(random_query());
        @(posedge i_clk);
        hold_requests <= hold_requests + 1;
        wait_drained();
        run_random(100, 29, 29);

        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
